// ----- design/frt_pkg.sv -----
// Shared types and constants of the frame chunk reassembly tracker.
package frt_pkg;

    // One table slot as held in the slot memory.
    typedef struct packed {
        logic        valid;
        logic [31:0] key;
        logic [31:0] total;
        logic [31:0] received;
        logic [47:0] created;
        logic [47:0] updated;
        logic [31:0] progress;
    } slot_t;

    // Configuration register indexes.
    localparam logic [2:0] CFG_RESTART_GAP = 3'd0;
    localparam logic [2:0] CFG_KEEP_WINDOW = 3'd1;
    localparam logic [2:0] CFG_STALL_LIMIT = 3'd2;
    localparam logic [2:0] CFG_HARD_LIMIT  = 3'd3;
    localparam logic [2:0] CFG_SWEEP_INTV  = 3'd4;
    localparam logic [2:0] CFG_OCC_LIMIT   = 3'd5;
    localparam logic [2:0] CFG_SYNC_CODE   = 3'd6;

    // Reset values of the configuration registers.
    localparam logic [31:0] RST_RESTART_GAP = 32'd1000;
    localparam logic [31:0] RST_KEEP_WINDOW = 32'd30;
    localparam logic [31:0] RST_STALL_LIMIT = 32'd1500;
    localparam logic [31:0] RST_HARD_LIMIT  = 32'd5000;
    localparam logic [15:0] RST_SWEEP_INTV  = 16'd64;
    localparam logic [8:0]  RST_OCC_LIMIT   = 9'd128;
    localparam logic [15:0] RST_SYNC_CODE   = 16'hFFFF;

    // Result status codes.
    localparam logic [2:0] ST_SHORT    = 3'd0;
    localparam logic [2:0] ST_BAD_SYNC = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_PARTIAL  = 3'd3;
    localparam logic [2:0] ST_COMPLETE = 3'd4;
    localparam logic [2:0] ST_EVICTED  = 3'd5;

    localparam logic [8:0] EVICT_MAX = 9'd511;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic prep;
        logic scan_start;
        logic init;
        logic clear;
        logic search;
        logic update;
        logic check;
        logic sweep;
        logic finish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic reject;
        logic jump;
        logic scan_done;
        logic do_sweep;
    } sts_t;

endpackage

// ----- design/frt_ctrl.sv -----
// Sequencing state machine of the frame chunk reassembly tracker.
module frt_ctrl
    import frt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic out_free,
    input  sts_t sts,
    output logic in_stall,
    output cmd_t cmd
);

    typedef enum logic [8:0] {
        S_INIT   = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_PREP   = 9'b000000100,
        S_CLEAR  = 9'b000001000,
        S_SEARCH = 9'b000010000,
        S_UPDATE = 9'b000100000,
        S_CHECK  = 9'b001000000,
        S_SWEEP  = 9'b010000000,
        S_FINISH = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_INIT:
            begin
                cmd.init = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep       = 1'b1;
                cmd.scan_start = 1'b1;
                if (sts.reject)
                begin
                    state_next = S_FINISH;
                end
                else if (sts.jump)
                begin
                    state_next = S_CLEAR;
                end
                else
                begin
                    state_next = S_SEARCH;
                end
            end
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.scan_done)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                cmd.search = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.check      = 1'b1;
                cmd.scan_start = 1'b1;
                if (sts.do_sweep)
                begin
                    state_next = S_SWEEP;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> out_free)
        else $error("result issued while output register is occupied");

    a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_PREP))
        else $error("accepted transaction did not start processing");

    a_sweep_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.sweep || cmd.search || cmd.clear) |-> !sts.reject)
        else $error("rejected packet reached the table");

endmodule

// ----- design/frt_dpath.sv -----
// Datapath of the frame chunk reassembly tracker: slot memory, per-stream state, config.
module frt_dpath
    import frt_pkg::*;
#(
    parameter int ENTRIES      = 256,
    parameter int HEADER_BYTES = 20,
    parameter int STREAMS      = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        stream,
    input  logic [15:0] datagram_length,
    input  logic [15:0] header_code,
    input  logic [31:0] frame_index,
    input  logic [31:0] announced_size,
    input  logic [47:0] now_ms,
    input  cmd_t        cmd,
    output sts_t        sts,
    output logic [2:0]  res_status,
    output logic [31:0] res_index,
    output logic [31:0] res_bytes,
    output logic [31:0] res_size,
    output logic        res_cleared,
    output logic [8:0]  res_evicted
);

    localparam int SLOTS = STREAMS * ENTRIES;
    localparam int AW    = $clog2(SLOTS);
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int STW   = (STREAMS > 1) ? $clog2(STREAMS) : 1;
    localparam int OW    = $clog2(ENTRIES + 1);
    localparam int LW    = (OW > 9) ? OW : 9;
    localparam logic [15:0] HB = 16'(HEADER_BYTES);

    // Configuration registers.
    logic [31:0] gap_reg, keep_reg, stall_reg, hard_reg;
    logic [15:0] intv_reg, sync_reg;
    logic [8:0]  olim_reg;

    // Per-stream state.
    logic [31:0]   hi_reg  [STREAMS];
    logic [15:0]   cd_reg  [STREAMS];
    logic [OW-1:0] occ_reg [STREAMS];

    // Latched packet.
    logic [STW-1:0] st_reg;
    logic [15:0]    len_reg, code_reg;
    logic [31:0]    idx_reg, ann_reg;
    logic [47:0]    now_reg;

    // Scan machinery.
    logic [CW-1:0] cnt_reg;
    logic          pend_reg;
    logic [AW-1:0] pend_addr_reg;

    // Per-packet working registers.
    logic          sweep_reg, cleared_reg, hit_reg, free_reg, full_reg, gone_reg;
    logic [AW-1:0] hit_addr_reg, free_addr_reg, slot_addr_reg;
    slot_t         hit_entry_reg, own_reg;
    logic [31:0]   cutoff_reg;
    logic [8:0]    evicted_reg;

    // Slot memory.
    slot_t         mem [SLOTS];
    slot_t         rdata_reg;
    logic          mem_we, mem_re;
    logic [AW-1:0] waddr, raddr;
    slot_t         wdata;

    logic [AW-1:0] base_addr;
    logic [CW-1:0] limit;
    logic          issue, reading;
    logic [31:0]   hi_cur;
    logic [15:0]   cd_cur;
    logic [OW-1:0] occ_cur;
    logic          reject, jump;

    assign base_addr = cmd.init ? '0 : AW'(AW'(st_reg) * AW'(ENTRIES));
    assign limit     = cmd.init ? CW'(SLOTS) : CW'(ENTRIES);
    assign reading   = cmd.search || cmd.sweep;
    assign issue     = (cmd.search || cmd.sweep || cmd.clear || cmd.init) && (cnt_reg < limit);
    assign raddr     = base_addr + AW'(cnt_reg);
    assign mem_re    = issue && reading;

    assign hi_cur  = hi_reg[st_reg];
    assign cd_cur  = cd_reg[st_reg];
    assign occ_cur = occ_reg[st_reg];
    assign reject  = (len_reg < HB) || (code_reg != sync_reg);
    assign jump    = (hi_cur != 32'd0) &&
                     (({1'b0, idx_reg} + {1'b0, gap_reg}) < {1'b0, hi_cur});

    assign sts.reject    = reject;
    assign sts.jump      = jump;
    assign sts.scan_done = (cnt_reg == limit) && !pend_reg;
    assign sts.do_sweep  = sweep_reg || (LW'(occ_cur) > LW'(olim_reg));

    // Entry written by the update step.
    slot_t         upd_entry;
    logic [AW-1:0] upd_addr;
    logic          upd_full;
    logic [32:0]   sum;

    always_comb
    begin
        upd_full = !hit_reg && !free_reg;
        upd_addr = hit_reg ? hit_addr_reg : free_addr_reg;
        if (hit_reg)
        begin
            upd_entry = hit_entry_reg;
        end
        else
        begin
            upd_entry          = rdata_reg;
            upd_entry.valid    = 1'b1;
            upd_entry.key      = idx_reg;
            upd_entry.total    = 32'd0;
            upd_entry.received = 32'd0;
        end
        if (upd_entry.total == 32'd0)
        begin
            upd_entry.total    = ann_reg;
            upd_entry.created  = now_reg;
            upd_entry.updated  = now_reg;
            upd_entry.progress = 32'd0;
        end
        sum = {1'b0, upd_entry.received} + {17'd0, len_reg - HB};
        if (len_reg > HB)
        begin
            upd_entry.received = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            upd_entry.updated  = now_reg;
        end
    end

    // Sweep decision on the entry just read.
    logic        sw_drop, sw_prog;
    logic [47:0] d_upd, d_cre;
    logic        old_upd, old_cre;

    always_comb
    begin
        d_upd   = now_reg - rdata_reg.updated;
        d_cre   = now_reg - rdata_reg.created;
        old_upd = (rdata_reg.updated != 48'd0) && (now_reg > rdata_reg.updated) &&
                  (d_upd > {16'd0, stall_reg});
        old_cre = (rdata_reg.created != 48'd0) && (now_reg > rdata_reg.created) &&
                  (d_cre > {16'd0, hard_reg});
        sw_drop = 1'b0;
        sw_prog = 1'b0;
        if (rdata_reg.valid)
        begin
            if (rdata_reg.key < cutoff_reg)
            begin
                sw_drop = 1'b1;
            end
            else if (rdata_reg.received == rdata_reg.progress)
            begin
                sw_drop = old_upd || old_cre;
            end
            else
            begin
                sw_prog = 1'b1;
            end
        end
    end

    logic sw_active, complete;
    assign sw_active = cmd.sweep && pend_reg;
    assign complete  = !reject && !full_reg && !gone_reg && (own_reg.total != 32'd0) &&
                       (own_reg.received >= own_reg.total);

    // Memory write source selection.
    always_comb
    begin
        mem_we = 1'b0;
        waddr  = raddr;
        wdata  = rdata_reg;
        if (cmd.init || cmd.clear)
        begin
            mem_we      = issue;
            wdata       = '0;
        end
        else if (cmd.update)
        begin
            mem_we = !upd_full;
            waddr  = upd_addr;
            wdata  = upd_entry;
        end
        else if (sw_active)
        begin
            mem_we = sw_drop || sw_prog;
            waddr  = pend_addr_reg;
            if (sw_drop)
            begin
                wdata.valid = 1'b0;
            end
            else
            begin
                wdata.progress = rdata_reg.received;
            end
        end
        else if (cmd.finish)
        begin
            mem_we      = complete;
            waddr       = slot_addr_reg;
            wdata       = own_reg;
            wdata.valid = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg   <= RST_RESTART_GAP;
            keep_reg  <= RST_KEEP_WINDOW;
            stall_reg <= RST_STALL_LIMIT;
            hard_reg  <= RST_HARD_LIMIT;
            intv_reg  <= RST_SWEEP_INTV;
            olim_reg  <= RST_OCC_LIMIT;
            sync_reg  <= RST_SYNC_CODE;
            for (int s = 0; s < STREAMS; s++)
            begin
                hi_reg[s]  <= '0;
                cd_reg[s]  <= RST_SWEEP_INTV;
                occ_reg[s] <= '0;
            end
            cnt_reg  <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RESTART_GAP: gap_reg   <= cfg_data;
                    CFG_KEEP_WINDOW: keep_reg  <= cfg_data;
                    CFG_STALL_LIMIT: stall_reg <= cfg_data;
                    CFG_HARD_LIMIT:  hard_reg  <= cfg_data;
                    CFG_SWEEP_INTV:  intv_reg  <= cfg_data[15:0];
                    CFG_OCC_LIMIT:   olim_reg  <= cfg_data[8:0];
                    CFG_SYNC_CODE:   sync_reg  <= cfg_data[15:0];
                    default:         ;
                endcase
            end

            if (cmd.scan_start)
            begin
                cnt_reg  <= '0;
                pend_reg <= 1'b0;
            end
            else
            begin
                if (issue)
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                end
                pend_reg <= issue && reading;
            end

            if (cmd.prep && !reject)
            begin
                if (cd_cur <= 16'd1)
                begin
                    cd_reg[st_reg] <= (intv_reg != 16'd0) ? intv_reg : 16'd1;
                end
                else
                begin
                    cd_reg[st_reg] <= cd_cur - 16'd1;
                end
                if (jump)
                begin
                    hi_reg[st_reg]  <= idx_reg;
                    occ_reg[st_reg] <= '0;
                end
                else if (idx_reg > hi_cur)
                begin
                    hi_reg[st_reg] <= idx_reg;
                end
            end
            else if (cmd.update && !hit_reg && free_reg)
            begin
                occ_reg[st_reg] <= occ_cur + OW'(1);
            end
            else if (sw_active && sw_drop)
            begin
                occ_reg[st_reg] <= occ_cur - OW'(1);
            end
            else if (cmd.finish && complete)
            begin
                occ_reg[st_reg] <= occ_cur - OW'(1);
            end
        end
    end

    // Payload and per-packet working registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            st_reg   <= (STREAMS > 1) ? STW'(stream) : '0;
            len_reg  <= datagram_length;
            code_reg <= header_code;
            idx_reg  <= frame_index;
            ann_reg  <= announced_size;
            now_reg  <= now_ms;
        end
        if (issue)
        begin
            pend_addr_reg <= raddr;
        end
        if (cmd.prep)
        begin
            sweep_reg   <= (cd_cur <= 16'd1);
            cleared_reg <= jump && !reject;
            hit_reg     <= 1'b0;
            free_reg    <= 1'b0;
            full_reg    <= 1'b0;
            gone_reg    <= 1'b0;
            evicted_reg <= 9'd0;
        end
        if (cmd.search && pend_reg)
        begin
            if (rdata_reg.valid && (rdata_reg.key == idx_reg) && !hit_reg)
            begin
                hit_reg       <= 1'b1;
                hit_addr_reg  <= pend_addr_reg;
                hit_entry_reg <= rdata_reg;
            end
            if (!rdata_reg.valid && !free_reg)
            begin
                free_reg      <= 1'b1;
                free_addr_reg <= pend_addr_reg;
            end
        end
        if (cmd.update)
        begin
            full_reg      <= upd_full;
            own_reg       <= upd_entry;
            slot_addr_reg <= upd_addr;
        end
        if (cmd.check)
        begin
            cutoff_reg <= (hi_cur > keep_reg) ? (hi_cur - keep_reg) : 32'd0;
        end
        if (sw_active && sw_drop)
        begin
            if (evicted_reg != EVICT_MAX)
            begin
                evicted_reg <= evicted_reg + 9'd1;
            end
            if (!full_reg && (pend_addr_reg == slot_addr_reg))
            begin
                gone_reg <= 1'b1;
            end
        end
    end

    // Result fields, valid while the controller finishes a packet.
    always_comb
    begin
        res_index   = idx_reg;
        res_bytes   = 32'd0;
        res_size    = 32'd0;
        res_cleared = 1'b0;
        res_evicted = 9'd0;
        if (len_reg < HB)
        begin
            res_status = ST_SHORT;
        end
        else if (code_reg != sync_reg)
        begin
            res_status = ST_BAD_SYNC;
        end
        else
        begin
            res_cleared = cleared_reg;
            res_evicted = evicted_reg;
            if (full_reg)
            begin
                res_status = ST_FULL;
            end
            else
            begin
                res_bytes = own_reg.received;
                res_size  = own_reg.total;
                if (gone_reg)
                begin
                    res_status = ST_EVICTED;
                end
                else if (complete)
                begin
                    res_status = ST_COMPLETE;
                end
                else
                begin
                    res_status = ST_PARTIAL;
                end
            end
        end
    end

endmodule

// ----- design/frame_chunk_reassembly_tracker.sv -----
// Top level of the frame chunk reassembly tracker with its output register.
//
// Packet headers enter on the input channel (in_valid / in_stall); one result
// transaction per packet leaves on the output channel (out_valid / out_stall).
// Configuration registers are written through cfg_we, cfg_index and cfg_data;
// the user must write them only while no packet is in flight, as the block
// itself does not enforce this. One packet is handled at a time. A packet
// with a short length or a wrong sync code goes straight from its checks to
// its result. Otherwise the stream's ENTRIES slots are scanned once to find
// or allocate the entry, a backward jump adds a clearing pass, and a due
// sweep adds a second scan. The slot memory is read at one slot per cycle.
// After reset the slot memory is cleared, one slot a cycle; no packet is
// accepted meanwhile.
// A result waits in the output register while the receiver stalls; the next
// packet is still accepted and worked on, and held back only at its own end.
module frame_chunk_reassembly_tracker
    import frt_pkg::*;
#(
    parameter int ENTRIES      = 256,
    parameter int HEADER_BYTES = 20,
    parameter int STREAMS      = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        stream,
    input  logic [15:0] datagram_length,
    input  logic [15:0] header_code,
    input  logic [31:0] frame_index,
    input  logic [31:0] announced_size,
    input  logic [47:0] now_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [31:0] result_index,
    output logic [31:0] bytes_so_far,
    output logic [31:0] frame_size,
    output logic        table_cleared,
    output logic [8:0]  evicted_count
);

    cmd_t        cmd;
    sts_t        sts;
    logic        out_free;
    logic        out_valid_reg;
    logic [2:0]  r_status;
    logic [31:0] r_index, r_bytes, r_size;
    logic        r_cleared;
    logic [8:0]  r_evicted;

    assign out_free = !out_valid_reg || !out_stall;

    frt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_free (out_free),
        .sts      (sts),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    frt_dpath #(
        .ENTRIES      (ENTRIES),
        .HEADER_BYTES (HEADER_BYTES),
        .STREAMS      (STREAMS)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .stream          (stream),
        .datagram_length (datagram_length),
        .header_code     (header_code),
        .frame_index     (frame_index),
        .announced_size  (announced_size),
        .now_ms          (now_ms),
        .cmd             (cmd),
        .sts             (sts),
        .res_status      (r_status),
        .res_index       (r_index),
        .res_bytes       (r_bytes),
        .res_size        (r_size),
        .res_cleared     (r_cleared),
        .res_evicted     (r_evicted)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            status        <= r_status;
            result_index  <= r_index;
            bytes_so_far  <= r_bytes;
            frame_size    <= r_size;
            table_cleared <= r_cleared;
            evicted_count <= r_evicted;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the frame chunk reassembly tracker.
`timescale 1ns / 1ps

module tb_top;
    import frt_pkg::*;

    localparam int NUM_ENTRIES = 256;
    localparam int HDR_BYTES   = 20;
    localparam int CYCLE_LIMIT = 20000000;

    typedef struct packed {
        logic        strm;
        logic [15:0] len;
        logic [15:0] code;
        logic [31:0] idx;
        logic [31:0] ann;
        logic [47:0] now;
    } packet_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] idx;
        logic [31:0] bytes;
        logic [31:0] size;
        logic        cleared;
        logic [8:0]  evicted;
    } verdict_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        stream;
    logic [15:0] datagram_length;
    logic [15:0] header_code;
    logic [31:0] frame_index;
    logic [31:0] announced_size;
    logic [47:0] now_ms;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  status;
    logic [31:0] result_index;
    logic [31:0] bytes_so_far;
    logic [31:0] frame_size;
    logic        table_cleared;
    logic [8:0]  evicted_count;

    frame_chunk_reassembly_tracker u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .stream          (stream),
        .datagram_length (datagram_length),
        .header_code     (header_code),
        .frame_index     (frame_index),
        .announced_size  (announced_size),
        .now_ms          (now_ms),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .result_index    (result_index),
        .bytes_so_far    (bytes_so_far),
        .frame_size      (frame_size),
        .table_cleared   (table_cleared),
        .evicted_count   (evicted_count)
    );

    // Mirror of the configuration registers.
    logic [31:0] m_gap, m_keep, m_stall, m_hard;
    logic [15:0] m_intv, m_sync;
    logic [8:0]  m_occ;

    // Mirror of the per-stream tracking state.
    logic [31:0] top_index [2];
    logic [15:0] countdown [2];
    logic [8:0]  used_count [2];
    bit          slot_used [2][NUM_ENTRIES];
    logic [31:0] slot_id [2][NUM_ENTRIES];
    logic [31:0] slot_want [2][NUM_ENTRIES];
    logic [31:0] slot_got [2][NUM_ENTRIES];
    logic [31:0] slot_seen [2][NUM_ENTRIES];
    logic [47:0] slot_born [2][NUM_ENTRIES];
    logic [47:0] slot_touched [2][NUM_ENTRIES];

    packet_t  pending_packets [$];
    verdict_t expected_verdicts [$];
    packet_t  cur_packet;
    int       errors = 0;
    int       accepted = 0;
    int       cycles = 0;
    int       hold_left;
    bit       hold_done;
    bit       no_idle = 0;
    logic [31:0] base_idx [2];
    logic [47:0] clock_ms;

    function automatic bit aged(logic [47:0] now, logic [47:0] then, logic [31:0] lim);
        return then != 0 && now > then && (now - then) > {16'b0, lim};
    endfunction

    function automatic verdict_t track_packet(packet_t p);
        verdict_t r;
        int s, i, slot, evicted;
        bit found, full, sweep, gone, drop;
        logic [31:0] cutoff;
        logic [32:0] sum;
        r = '0;
        r.idx = p.idx;
        s = p.strm;
        slot = 0;
        evicted = 0;
        found = 0;
        full = 0;
        gone = 0;
        if (p.len < HDR_BYTES)
        begin
            r.status = ST_SHORT;
            return r;
        end
        if (p.code != m_sync)
        begin
            r.status = ST_BAD_SYNC;
            return r;
        end
        if (countdown[s] <= 1)
        begin
            sweep = 1;
            countdown[s] = (m_intv == 0) ? 16'd1 : m_intv;
        end
        else
        begin
            sweep = 0;
            countdown[s] = countdown[s] - 16'd1;
        end
        if (top_index[s] != 0 && ({1'b0, p.idx} + {1'b0, m_gap}) < {1'b0, top_index[s]})
        begin
            for (i = 0; i < NUM_ENTRIES; i++)
                slot_used[s][i] = 0;
            used_count[s] = 0;
            top_index[s] = p.idx;
            r.cleared = 1;
        end
        else if (p.idx > top_index[s])
        begin
            top_index[s] = p.idx;
        end
        for (i = 0; i < NUM_ENTRIES && !found; i++)
            if (slot_used[s][i] && slot_id[s][i] == p.idx)
            begin
                slot = i;
                found = 1;
            end
        if (!found)
        begin
            for (i = 0; i < NUM_ENTRIES && !found; i++)
                if (!slot_used[s][i])
                begin
                    slot = i;
                    found = 1;
                end
            if (found)
            begin
                slot_used[s][slot] = 1;
                slot_id[s][slot] = p.idx;
                slot_want[s][slot] = 0;
                slot_got[s][slot] = 0;
                used_count[s] = used_count[s] + 9'd1;
            end
            else
            begin
                full = 1;
            end
        end
        if (!full)
        begin
            if (slot_want[s][slot] == 0)
            begin
                slot_want[s][slot] = p.ann;
                slot_born[s][slot] = p.now;
                slot_touched[s][slot] = p.now;
                slot_seen[s][slot] = 0;
            end
            if (p.len > HDR_BYTES)
            begin
                sum = {1'b0, slot_got[s][slot]} + 33'(p.len - HDR_BYTES);
                slot_got[s][slot] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                slot_touched[s][slot] = p.now;
            end
        end
        if (sweep || used_count[s] > m_occ)
        begin
            cutoff = (top_index[s] > m_keep) ? top_index[s] - m_keep : 32'd0;
            for (i = 0; i < NUM_ENTRIES; i++)
            begin
                drop = 0;
                if (slot_used[s][i])
                begin
                    if (slot_id[s][i] < cutoff)
                        drop = 1;
                    else if (slot_got[s][i] == slot_seen[s][i])
                        drop = aged(p.now, slot_touched[s][i], m_stall) ||
                               aged(p.now, slot_born[s][i], m_hard);
                    else
                        slot_seen[s][i] = slot_got[s][i];
                    if (drop)
                    begin
                        slot_used[s][i] = 0;
                        used_count[s] = used_count[s] - 9'd1;
                        evicted++;
                        if (!full && i == slot)
                            gone = 1;
                    end
                end
            end
        end
        if (full)
        begin
            r.status = ST_FULL;
        end
        else
        begin
            r.bytes = slot_got[s][slot];
            r.size = slot_want[s][slot];
            if (gone)
            begin
                r.status = ST_EVICTED;
            end
            else if (slot_want[s][slot] > 0 && slot_got[s][slot] >= slot_want[s][slot])
            begin
                r.status = ST_COMPLETE;
                slot_used[s][slot] = 0;
                used_count[s] = used_count[s] - 9'd1;
            end
            else
            begin
                r.status = ST_PARTIAL;
            end
        end
        r.evicted = (evicted > 511) ? EVICT_MAX : 9'(evicted);
        return r;
    endfunction

    function automatic packet_t make_packet(logic s, logic [15:0] len, logic [31:0] idx,
                                            logic [31:0] ann, logic [47:0] now);
        packet_t p;
        p.strm = s;
        p.len = len;
        p.code = m_sync;
        p.idx = idx;
        p.ann = ann;
        p.now = now;
        return p;
    endfunction

    // Mostly well-formed traffic around a moving frame index, with some noise.
    function automatic packet_t random_packet();
        packet_t p;
        int s, pick;
        s = $urandom_range(1);
        p.strm = 1'(s);
        pick = $urandom_range(99);
        p.code = (pick < 5) ? 16'($urandom) : m_sync;
        pick = $urandom_range(99);
        if (pick < 4)
            p.len = 16'($urandom);
        else if (pick < 8)
            p.len = 16'($urandom_range(HDR_BYTES));
        else
            p.len = 16'($urandom_range(1500, HDR_BYTES));
        base_idx[s] = base_idx[s] + $urandom_range(3);
        pick = $urandom_range(99);
        if (pick < 3)
        begin
            p.idx = $urandom;
        end
        else if (pick < 6)
        begin
            p.idx = base_idx[s] - $urandom_range(5000);
        end
        else
        begin
            p.idx = base_idx[s] + $urandom_range(40);
        end
        pick = $urandom_range(99);
        if (pick < 5)
            p.ann = 0;
        else if (pick < 8)
            p.ann = $urandom;
        else
            p.ann = $urandom_range(8000, 100);
        clock_ms = clock_ms + $urandom_range(300);
        pick = $urandom_range(99);
        if (pick < 3)
            p.now = {16'($urandom), 32'($urandom)};
        else if (pick < 6)
            p.now = clock_ms - $urandom_range(4000);
        else
            p.now = clock_ms;
        return p;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_RESTART_GAP: m_gap = val;
            CFG_KEEP_WINDOW: m_keep = val;
            CFG_STALL_LIMIT: m_stall = val;
            CFG_HARD_LIMIT:  m_hard = val;
            CFG_SWEEP_INTV:  m_intv = val[15:0];
            CFG_OCC_LIMIT:   m_occ = val[8:0];
            CFG_SYNC_CODE:   m_sync = val[15:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // The last packet may be taken from the queue before its valid is seen,
    // so the check on valid and results waits for the following edge.
    task automatic drain();
        wait (pending_packets.size() == 0);
        @(posedge clk);
        wait (!in_valid && expected_verdicts.size() == 0);
        repeat (20) @(posedge clk);
    endtask

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Sender: offers queued packets and predicts each one at acceptance.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            stream <= 1'b0;
            datagram_length <= '0;
            header_code <= '0;
            frame_index <= '0;
            announced_size <= '0;
            now_ms <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_verdicts.push_back(track_packet(cur_packet));
                accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_packets.size() > 0 && (no_idle || $urandom_range(99) >= 25))
                begin
                    cur_packet = pending_packets.pop_front();
                    in_valid <= 1'b1;
                    stream <= cur_packet.strm;
                    datagram_length <= cur_packet.len;
                    header_code <= cur_packet.code;
                    frame_index <= cur_packet.idx;
                    announced_size <= cur_packet.ann;
                    now_ms <= cur_packet.now;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // One long hold-off of the receiver lets the block fill up and stall its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && accepted >= 300)
        begin
            hold_done <= 1'b1;
            hold_left <= 3000;
        end
    end

    // Receiver: checks every result transaction and applies back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual status %0d index %0h",
                             $time, status, result_index);
                    errors++;
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d", $time, want.status, status);
                        errors++;
                    end
                    if (result_index !== want.idx)
                    begin
                        $display("%0t: result_index expected %0h actual %0h",
                                 $time, want.idx, result_index);
                        errors++;
                    end
                    if (bytes_so_far !== want.bytes)
                    begin
                        $display("%0t: bytes_so_far expected %0d actual %0d",
                                 $time, want.bytes, bytes_so_far);
                        errors++;
                    end
                    if (frame_size !== want.size)
                    begin
                        $display("%0t: frame_size expected %0d actual %0d",
                                 $time, want.size, frame_size);
                        errors++;
                    end
                    if (table_cleared !== want.cleared)
                    begin
                        $display("%0t: table_cleared expected %0d actual %0d",
                                 $time, want.cleared, table_cleared);
                        errors++;
                    end
                    if (evicted_count !== want.evicted)
                    begin
                        $display("%0t: evicted_count expected %0d actual %0d",
                                 $time, want.evicted, evicted_count);
                        errors++;
                    end
                end
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 25);
            end
        end
    end

    initial
    begin
        int s, i, n, ph;
        logic [47:0] t;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        m_gap = RST_RESTART_GAP;
        m_keep = RST_KEEP_WINDOW;
        m_stall = RST_STALL_LIMIT;
        m_hard = RST_HARD_LIMIT;
        m_intv = RST_SWEEP_INTV;
        m_occ = RST_OCC_LIMIT;
        m_sync = RST_SYNC_CODE;
        for (s = 0; s < 2; s++)
        begin
            top_index[s] = 0;
            countdown[s] = RST_SWEEP_INTV;
            used_count[s] = 0;
            base_idx[s] = 32'd100;
            for (i = 0; i < NUM_ENTRIES; i++)
                slot_used[s][i] = 0;
        end
        clock_ms = 48'd1000;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed packets under the reset settings.
        pending_packets.push_back(make_packet(1'b0, 16'd0, 32'd5, 32'd100, 48'd10));
        pending_packets.push_back(make_packet(1'b1, 16'd19, 32'd5, 32'd100, 48'd10));
        pending_packets.push_back(make_packet(1'b0, 16'hFFFF, 32'd5, 32'd100, 48'd10));
        pending_packets[$].code = 16'h0000;
        pending_packets.push_back(make_packet(1'b0, 16'd70, 32'd5, 32'd100, 48'd20));
        pending_packets.push_back(make_packet(1'b0, 16'd20, 32'd5, 32'd100, 48'd30));
        pending_packets.push_back(make_packet(1'b0, 16'd70, 32'd5, 32'd100, 48'd40));
        pending_packets.push_back(make_packet(1'b0, 16'd100, 32'd7, 32'd0, 48'd50));
        pending_packets.push_back(make_packet(1'b0, 16'd100, 32'd7, 32'd0, 48'd60));
        pending_packets.push_back(make_packet(1'b0, 16'd100, 32'd7, 32'd60, 48'd5));
        pending_packets.push_back(make_packet(1'b1, 16'hFFFF, 32'd9, 32'hFFFF_FFFF,
                                              48'hFFFF_FFFF_FFFF));
        pending_packets.push_back(make_packet(1'b1, 16'd40, 32'hFFFF_FFFF, 32'd1000, 48'd0));
        pending_packets.push_back(make_packet(1'b1, 16'd40, 32'd10, 32'd1000, 48'd70));
        pending_packets.push_back(make_packet(1'b1, 16'd40, 32'd0, 32'd30, 48'd80));
        pending_packets.push_back(make_packet(1'b0, 16'd21, 32'd6, 32'd1, 48'd90));
        drain();

        // Fill stream 0 until new frames find no free slot.
        write_reg(CFG_RESTART_GAP, 32'hFFFF_FFFF);
        write_reg(CFG_KEEP_WINDOW, 32'hFFFF_FFFF);
        write_reg(CFG_STALL_LIMIT, 32'hFFFF_FFFF);
        write_reg(CFG_HARD_LIMIT, 32'hFFFF_FFFF);
        write_reg(CFG_SWEEP_INTV, 32'd65535);
        write_reg(CFG_OCC_LIMIT, 32'd256);
        write_reg(CFG_SYNC_CODE, 32'h0000_1234);
        for (i = 0; i < 262; i++)
            pending_packets.push_back(make_packet(1'b0, 16'd30, 32'(i + 1000), 32'd100000,
                                                  48'(i + 100)));
        drain();

        // Every packet sweeps with zero limits, so stalled entries go at once.
        no_idle = 1;
        write_reg(CFG_RESTART_GAP, 32'd0);
        write_reg(CFG_KEEP_WINDOW, 32'd0);
        write_reg(CFG_STALL_LIMIT, 32'd0);
        write_reg(CFG_HARD_LIMIT, 32'd0);
        write_reg(CFG_SWEEP_INTV, 32'd1);
        write_reg(CFG_OCC_LIMIT, 32'd0);
        write_reg(CFG_SYNC_CODE, 32'h0000_0000);
        t = 48'd5000;
        for (i = 0; i < 120; i++)
        begin
            t = t + $urandom_range(3);
            pending_packets.push_back(make_packet(1'($urandom_range(1)),
                16'($urandom_range(60, HDR_BYTES)), 32'(2000 + $urandom_range(8)),
                32'($urandom_range(300)), t));
        end
        drain();
        no_idle = 0;

        for (ph = 0; ph < 5; ph++)
        begin
            if (ph == 0)
            begin
                write_reg(CFG_RESTART_GAP, RST_RESTART_GAP);
                write_reg(CFG_KEEP_WINDOW, RST_KEEP_WINDOW);
                write_reg(CFG_STALL_LIMIT, RST_STALL_LIMIT);
                write_reg(CFG_HARD_LIMIT, RST_HARD_LIMIT);
                write_reg(CFG_SWEEP_INTV, 32'(RST_SWEEP_INTV));
                write_reg(CFG_OCC_LIMIT, 32'(RST_OCC_LIMIT));
                write_reg(CFG_SYNC_CODE, 32'(RST_SYNC_CODE));
            end
            else
            begin
                write_reg(CFG_RESTART_GAP, ($urandom_range(1)) ? $urandom_range(20000) : $urandom);
                write_reg(CFG_KEEP_WINDOW, ($urandom_range(2) == 0) ? 32'hFFFF_FFFF
                                                                     : $urandom_range(100));
                write_reg(CFG_STALL_LIMIT, $urandom_range(3000));
                write_reg(CFG_HARD_LIMIT, ($urandom_range(3) == 0) ? 32'hFFFF_FFFF
                                                                    : $urandom_range(8000));
                write_reg(CFG_SWEEP_INTV, ($urandom_range(4) == 0) ? 32'd65535
                                                                    : $urandom_range(100, 1));
                write_reg(CFG_OCC_LIMIT, $urandom_range(256));
                write_reg(CFG_SYNC_CODE, $urandom_range(65535));
            end
            no_idle = (ph == 2);
            n = 290;
            for (i = 0; i < n; i++)
                pending_packets.push_back(random_packet());
            // A pause until every result has returned before the next phase.
            drain();
        end

        no_idle = 0;
        repeat (2000) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- frame_chunk_reassembly_tracker.f -----
design/frt_pkg.sv
design/frt_ctrl.sv
design/frt_dpath.sv
design/frame_chunk_reassembly_tracker.sv
tb/sv/tb_top.sv
